// ----- src/vel_pkg.sv -----
// ----------------------------------------------------------------------------
// vel_pkg: shared types and constants for the vector length block
// Sum width, result width, default parameters, and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vel_pkg;

  localparam int SUM_BITS          = 40;
  localparam int NORM_W            = 28;
  localparam int ELEMENT_WIDTH_DEF = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [SUM_BITS-1:0] SUM_MAX  = '1;
  localparam logic [NORM_W-1:0]   NORM_MAX = '1;

  typedef struct packed {
    logic accept;     // element transfer this cycle
    logic root_load;  // final sum into the root unit, clear accumulator
    logic root_step;  // one root digit
  } vel_cmd_t;

  typedef struct packed {
    logic root_last;  // current step is the final root digit
  } vel_stat_t;

endpackage

// ----- src/vel_ctrl.sv -----
// ----------------------------------------------------------------------------
// vel_ctrl: sequencer for the vector length block
// Tracks the closing element through square, accumulate and root phases
// and raises the result strobe.
// ----------------------------------------------------------------------------
module vel_ctrl
  import vel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_is_last,
  input  vel_stat_t stat,
  output vel_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_LOAD = 5'b00100,
    S_ROOT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy      = !(state_r == S_IDLE || state_r == S_DONE);
  assign accept    = start && !busy;
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    cmd.accept    = accept;
    cmd.root_load = (state_r == S_LOAD);
    cmd.root_step = (state_r == S_ROOT);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE, S_DONE: begin
        if (accept && in_is_last) state_nxt = S_SQ;
        else                      state_nxt = S_IDLE;
      end
      S_SQ:   state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_ROOT;
      S_ROOT: begin
        if (stat.root_last) state_nxt = S_DONE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- src/vel_dp.sv -----
// ----------------------------------------------------------------------------
// vel_dp: datapath for the vector length block
// Squares each element, accumulates with saturation at 2^40-1, and runs a
// restoring square root one digit per cycle on the scaled final sum.
// ----------------------------------------------------------------------------
module vel_dp
  import vel_pkg::*;
#(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vel_cmd_t                        cmd,
  input  logic signed [ELEMENT_WIDTH-1:0] in_element,
  output vel_stat_t                       stat,
  output logic [NORM_W-1:0]               out_norm_fixed,
  output logic                            out_saturated
);

  localparam int SQ_W  = 2 * ELEMENT_WIDTH;
  localparam int ACC_W = ((SQ_W > SUM_BITS) ? SQ_W : SUM_BITS) + 1;
  localparam int RP    = (SUM_BITS + 2 * FRACTION_BITS + 1) / 2;
  localparam int SC_W  = 2 * RP;
  localparam int REM_W = RP + 2;
  localparam int CNT_W = $clog2(RP);
  localparam int CMP_W = (RP > NORM_W) ? RP : NORM_W;

  // squaring stage
  logic [ELEMENT_WIDTH-1:0] mag;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic                     sq_vld_r;

  // two's complement negate also gives the right magnitude for the most
  // negative code
  assign mag    = in_element[ELEMENT_WIDTH-1] ? (~in_element + 1'b1) : in_element;
  assign sq_nxt = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r <= 1'b0;
    else        sq_vld_r <= cmd.accept;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) sq_r <= sq_nxt;
  end

  // saturating accumulator
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [ACC_W-1:0]    sum_ext;

  assign sum_ext = ACC_W'(sum_r) + ACC_W'(sq_r);

  always_comb begin
    sum_nxt = sum_r;
    priority if (cmd.root_load) begin
      sum_nxt = '0;
    end else if (sq_vld_r) begin
      if (sum_ext >= ACC_W'(SUM_MAX)) sum_nxt = SUM_MAX;
      else                           sum_nxt = sum_ext[SUM_BITS-1:0];
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sum_r <= '0;
    else        sum_r <= sum_nxt;
  end

  // digit-by-digit root of sum * 4^FRACTION_BITS
  logic [SC_W-1:0]  sh_r;
  logic [RP-1:0]    root_r;
  logic [REM_W-1:0] rem_r, rem_cat, trial;
  logic [CNT_W-1:0] cnt_r;
  logic             sat_r;

  assign rem_cat = {rem_r[REM_W-3:0], sh_r[SC_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      sh_r   <= SC_W'(sum_r) << (2 * FRACTION_BITS);
      root_r <= '0;
      rem_r  <= '0;
      cnt_r  <= '0;
      sat_r  <= (sum_r == SUM_MAX);
    end else if (cmd.root_step) begin
      sh_r  <= sh_r << 2;
      cnt_r <= cnt_r + 1'b1;
      if (rem_cat >= trial) begin
        rem_r  <= rem_cat - trial;
        root_r <= {root_r[RP-2:0], 1'b1};
      end else begin
        rem_r  <= rem_cat;
        root_r <= {root_r[RP-2:0], 1'b0};
      end
    end
  end

  assign stat.root_last = (cnt_r == CNT_W'(RP - 1));

  logic [CMP_W-1:0] root_w;
  assign root_w         = CMP_W'(root_r);
  assign out_norm_fixed = (root_w > CMP_W'(NORM_MAX)) ? NORM_MAX : root_w[NORM_W-1:0];
  assign out_saturated  = sat_r;

endmodule

// ----- src/vector_euclidean_length.sv -----
// ----------------------------------------------------------------------------
// vector_euclidean_length: streaming Euclidean norm of an integer vector
// Elements come in one per transfer; the transfer marked last closes the
// vector and yields floor(sqrt(sum of squares) * 2^FRACTION_BITS) plus a
// flag for a saturated 40-bit sum.
// ----------------------------------------------------------------------------
// Usage: elements that are not last are taken one per cycle with busy low.
// After the transfer of the last element, busy stays high through the
// phases square, accumulate, load and root (one root digit
// per cycle for 20 + FRACTION_BITS digits); the result strobe out_valid is
// high in the next cycle, in which busy is already low and a new vector may
// begin. The result is shown for that one cycle only, so the receiver must
// take it then; the sum is cleared for the next vector.
module vector_euclidean_length
  import vel_pkg::*;
#(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ELEMENT_WIDTH-1:0] in_element,
  input  logic                            in_is_last,
  output logic                            out_valid,
  output logic [NORM_W-1:0]               out_norm_fixed,
  output logic                            out_saturated
);

  vel_cmd_t  cmd;
  vel_stat_t stat;

  vel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_is_last(in_is_last),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  vel_dp #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_element    (in_element),
    .stat          (stat),
    .out_norm_fixed(out_norm_fixed),
    .out_saturated (out_saturated)
  );

endmodule

// ----- src/vel_checker.sv -----
// ----------------------------------------------------------------------------
// vel_checker: port-level checks for the vector length block
// Watches the transfer handshake and result strobe over time.
// ----------------------------------------------------------------------------
module vel_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_is_last,
  input logic out_valid
);

  // a closing transfer must make the block busy
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_is_last) |=> busy)
    else $error("closing transfer did not raise busy");

  // the result follows a busy root phase
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding busy phase");

  // the strobe is a single-cycle pulse
  a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the block is ready again while the result is shown
  a_res_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy during result strobe");

endmodule

bind vector_euclidean_length vel_checker u_vel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_is_last(in_is_last),
  .out_valid (out_valid)
);

// ----- verif/vector_euclidean_length_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_euclidean_length_test: self-checking bench for the vector length block
// Streams signed elements in bursts with random gaps. A local model keeps
// the saturating 40-bit sum of squares and an integer square root of the
// sum scaled by 2^(2*FRACTION_BITS). Each closed vector queues one expected
// norm and flag, and a monitor matches every strobed result against it.
// ----------------------------------------------------------------------------
module vector_euclidean_length_test;
  import vel_pkg::*;

  localparam int ELEM_W      = ELEMENT_WIDTH_DEF;
  localparam int FRAC        = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;
  localparam int RANDOM_ITEMS = 650;

  typedef struct packed {
    logic [NORM_W-1:0] norm;
    logic              sat;
  } norm_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic signed [ELEM_W-1:0] in_element = '0;
  logic                     in_is_last = 1'b0;
  logic                     busy;
  logic                     out_valid;
  logic [NORM_W-1:0]        out_norm_fixed;
  logic                     out_saturated;

  norm_result_t       expected_norms[$];
  logic [SUM_BITS-1:0] square_total = '0;
  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  burst_left = 0;
  int                  items_sent = 0;

  vector_euclidean_length #(
    .ELEMENT_WIDTH(ELEM_W),
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_element    (in_element),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_norm_fixed(out_norm_fixed),
    .out_saturated (out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // floor(sqrt(s * 2^(2*FRAC))), built one root bit at a time
  function automatic logic [NORM_W-1:0] fixed_sqrt(input logic [SUM_BITS-1:0] s);
    logic [63:0] scaled;
    logic [63:0] root;
    logic [63:0] trial;
    scaled = {24'b0, s} << (2 * FRAC);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial <= 64'hFFFF_FFFF && trial * trial <= scaled)
        root = trial;
    end
    if (root > {36'b0, NORM_MAX})
      return NORM_MAX;
    return root[NORM_W-1:0];
  endfunction

  task automatic add_square(input logic signed [ELEM_W-1:0] e);
    longint mag;
    logic [63:0] sq;
    logic [63:0] limit;
    mag = e;
    if (mag < 0)
      mag = -mag;
    sq = 64'(mag) * 64'(mag);
    limit = {24'b0, SUM_MAX};
    if (sq >= limit || {24'b0, square_total} > limit - sq)
      square_total = SUM_MAX;
    else
      square_total = square_total + sq[SUM_BITS-1:0];
  endtask

  // one element transfer, then the sender's burst/gap pattern
  task automatic send_element(input logic signed [ELEM_W-1:0] e, input logic last);
    norm_result_t r;
    int gap;
    start      <= 1'b1;
    in_element <= e;
    in_is_last <= last;
    do @(posedge clk); while (busy);
    add_square(e);
    if (last) begin
      r.norm = fixed_sqrt(square_total);
      r.sat  = (square_total == SUM_MAX);
      expected_norms.push_back(r);
      square_total = '0;
    end
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_norms.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    norm_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_norms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: norm=%0d sat=%0b", out_norm_fixed, out_saturated);
      end else begin
        exp_r = expected_norms.pop_front();
        if (out_norm_fixed !== exp_r.norm || out_saturated !== exp_r.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected norm=%0d sat=%0b, got norm=%0d sat=%0b",
                     exp_r.norm, exp_r.sat, out_norm_fixed, out_saturated);
        end
      end
    end
  end

  logic signed [ELEM_W-1:0] MOST_NEG = {1'b1, {(ELEM_W-1){1'b0}}};
  logic signed [ELEM_W-1:0] MOST_POS = {1'b0, {(ELEM_W-1){1'b1}}};

  task automatic test_single_elements();
    send_element('0, 1'b1);
    send_element(16'sd1, 1'b1);
    send_element(-16'sd1, 1'b1);
    send_element(MOST_POS, 1'b1);
    send_element(MOST_NEG, 1'b1);
    send_element(16'sh5555, 1'b1);
    send_element(16'shAAAA, 1'b1);
  endtask

  task automatic test_short_vectors();
    send_element(16'sd3, 1'b0);
    send_element(-16'sd4, 1'b1);
    send_element(MOST_POS, 1'b0);
    send_element(MOST_NEG, 1'b0);
    send_element(MOST_NEG, 1'b1);
    send_element('0, 1'b0);
    send_element('0, 1'b0);
    send_element(16'sd2, 1'b1);
    send_element(-16'sd7, 1'b0);
    send_element(16'sd1, 1'b0);
    send_element(16'sd1, 1'b1);
  endtask

  // 1023 full squares plus one just short of 2^30 stays below the limit;
  // 1024 full squares reaches it, and more elements keep it pinned there
  task automatic test_sum_saturation();
    repeat (1023) send_element(MOST_NEG, 1'b0);
    send_element(MOST_POS, 1'b1);
    repeat (1024) send_element(MOST_NEG, 1'b0);
    send_element(16'sd5, 1'b0);
    send_element(MOST_POS, 1'b1);
  endtask

  function automatic logic signed [ELEM_W-1:0] random_element();
    case ($urandom_range(0, 7))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return ELEM_W'($urandom_range(0, 4)) - ELEM_W'(2);
      3: return ELEM_W'($urandom_range(0, 255));
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic test_random_vectors();
    int len;
    int target;
    bit paused;
    target = items_sent + RANDOM_ITEMS;
    paused = 1'b0;
    while (items_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++)
        send_element(random_element(), k == len - 1);
      // hold off once mid-run until the block has caught up
      if (!paused && items_sent >= target - RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_single_elements();
    test_short_vectors();
    test_sum_saturation();
    test_random_vectors();
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_norms.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
